FILE: hdl/cpt_pkg.sv
`default_nettype none

package cpt_pkg;

    typedef enum logic [2:0] {
        RGN_A     = 3'd0,
        RGN_B     = 3'd1,
        RGN_AB    = 3'd2,
        RGN_C     = 3'd3,
        RGN_AC    = 3'd4,
        RGN_BC    = 3'd5,
        RGN_INT   = 3'd6,
        RGN_DEGEN = 3'd7
    } region_t;

    // how a divider lane finishes: forced zero, forced one, or the quotient
    typedef struct packed {
        logic zero;
        logic one;
    } div_mode_t;

endpackage

`default_nettype wire

FILE: hdl/cpt_dots.sv
`default_nettype none

module cpt_dots #(
    parameter int CW = 24,
    parameter int F = 12,
    localparam int DW = CW + 1,
    localparam int PW = 2 * DW,
    localparam int SW = PW + 2,
    localparam int DTW = SW - F
) (
    input  logic                  clk,
    input  logic [2:0]            en,
    input  logic signed [CW-1:0]  p [3],
    input  logic signed [CW-1:0]  a [3],
    input  logic signed [CW-1:0]  b [3],
    input  logic signed [CW-1:0]  c [3],
    output logic signed [DTW-1:0] d [6],
    output logic signed [CW-1:0]  a_out [3],
    output logic signed [CW-1:0]  b_out [3],
    output logic signed [CW-1:0]  c_out [3],
    output logic signed [DW-1:0]  ab_out [3],
    output logic signed [DW-1:0]  ac_out [3],
    output logic signed [DW-1:0]  bc_out [3]
);

    logic signed [DW-1:0] ab1_reg [3];
    logic signed [DW-1:0] ac1_reg [3];
    logic signed [DW-1:0] ap1_reg [3];
    logic signed [DW-1:0] bp1_reg [3];
    logic signed [DW-1:0] cp1_reg [3];
    logic signed [DW-1:0] bc1_reg [3];
    logic signed [CW-1:0] a1_reg [3];
    logic signed [CW-1:0] b1_reg [3];
    logic signed [CW-1:0] c1_reg [3];

    logic signed [PW-1:0] pr2_reg [6][3];
    logic signed [DW-1:0] ab2_reg [3];
    logic signed [DW-1:0] ac2_reg [3];
    logic signed [DW-1:0] bc2_reg [3];
    logic signed [CW-1:0] a2_reg [3];
    logic signed [CW-1:0] b2_reg [3];
    logic signed [CW-1:0] c2_reg [3];

    // edge and offset vectors
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int k = 0; k < 3; k++)
            begin
                ab1_reg[k] <= DW'(b[k]) - DW'(a[k]);
                ac1_reg[k] <= DW'(c[k]) - DW'(a[k]);
                ap1_reg[k] <= DW'(p[k]) - DW'(a[k]);
                bp1_reg[k] <= DW'(p[k]) - DW'(b[k]);
                cp1_reg[k] <= DW'(p[k]) - DW'(c[k]);
                bc1_reg[k] <= DW'(c[k]) - DW'(b[k]);
                a1_reg[k] <= a[k];
                b1_reg[k] <= b[k];
                c1_reg[k] <= c[k];
            end
        end
    end

    // per-axis products for d1..d6
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int k = 0; k < 3; k++)
            begin
                pr2_reg[0][k] <= ab1_reg[k] * ap1_reg[k];
                pr2_reg[1][k] <= ac1_reg[k] * ap1_reg[k];
                pr2_reg[2][k] <= ab1_reg[k] * bp1_reg[k];
                pr2_reg[3][k] <= ac1_reg[k] * bp1_reg[k];
                pr2_reg[4][k] <= ab1_reg[k] * cp1_reg[k];
                pr2_reg[5][k] <= ac1_reg[k] * cp1_reg[k];
                ab2_reg[k] <= ab1_reg[k];
                ac2_reg[k] <= ac1_reg[k];
                bc2_reg[k] <= bc1_reg[k];
                a2_reg[k] <= a1_reg[k];
                b2_reg[k] <= b1_reg[k];
                c2_reg[k] <= c1_reg[k];
            end
        end
    end

    // sum and floor shift
    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int j = 0; j < 6; j++)
            begin
                d[j] <= DTW'((SW'(pr2_reg[j][0]) + SW'(pr2_reg[j][1])
                              + SW'(pr2_reg[j][2])) >>> F);
            end
            for (int k = 0; k < 3; k++)
            begin
                ab_out[k] <= ab2_reg[k];
                ac_out[k] <= ac2_reg[k];
                bc_out[k] <= bc2_reg[k];
                a_out[k] <= a2_reg[k];
                b_out[k] <= b2_reg[k];
                c_out[k] <= c2_reg[k];
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/cpt_cross.sv
`default_nettype none

module cpt_cross #(
    parameter int DTW = 40,
    localparam int L = DTW / 2,
    localparam int HW = DTW - L,
    localparam int PQ = 2 * DTW,
    localparam int XW = PQ + 1,
    localparam int VW = XW + 2
) (
    input  logic                  clk,
    input  logic [1:0]            en,
    input  logic signed [DTW-1:0] d_in [6],
    output logic signed [DTW-1:0] d_out [6],
    output logic signed [VW-1:0]  va,
    output logic signed [VW-1:0]  vb,
    output logic signed [VW-1:0]  vc,
    output logic signed [VW-1:0]  den
);

    // operand pairs: d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4
    localparam int XI [6] = '{0, 2, 4, 0, 2, 4};
    localparam int YI [6] = '{3, 1, 1, 5, 5, 3};

    logic signed [DTW+HW-1:0]  ph_reg [6];
    logic signed [DTW+L:0]     pl_reg [6];
    logic signed [DTW-1:0]     da_reg [6];
    logic signed [PQ-1:0]      full [6];
    logic signed [XW-1:0]      va_w;
    logic signed [XW-1:0]      vb_w;
    logic signed [XW-1:0]      vc_w;

    // split the second operand into a signed high and an unsigned low half
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int j = 0; j < 6; j++)
            begin
                ph_reg[j] <= d_in[XI[j]] * $signed(d_in[YI[j]][DTW-1:L]);
                pl_reg[j] <= d_in[XI[j]] * $signed({1'b0, d_in[YI[j]][L-1:0]});
                da_reg[j] <= d_in[j];
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < 6; j++)
        begin
            full[j] = (PQ'(ph_reg[j]) <<< L) + PQ'(pl_reg[j]);
        end
        vc_w = XW'(full[0]) - XW'(full[1]);
        vb_w = XW'(full[2]) - XW'(full[3]);
        va_w = XW'(full[4]) - XW'(full[5]);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            va <= VW'(va_w);
            vb <= VW'(vb_w);
            vc <= VW'(vc_w);
            den <= VW'(va_w) + VW'(vb_w) + VW'(vc_w);
            for (int j = 0; j < 6; j++)
            begin
                d_out[j] <= da_reg[j];
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/cpt_div.sv
`default_nettype none

module cpt_div #(
    parameter int VW = 83,
    parameter int F = 12
) (
    input  logic                 clk,
    input  logic [F-1:0]         en,
    input  logic [VW-2:0]        rem_in,
    input  logic [VW-2:0]        den_in,
    input  cpt_pkg::div_mode_t   mode_in,
    output logic [F:0]           q_out
);

    logic [VW-2:0]       rem_reg [F];
    logic [VW-2:0]       den_reg [F];
    logic [F-1:0]        q_reg [F];
    cpt_pkg::div_mode_t  mode_reg [F];

    // restoring division, one quotient bit per stage
    for (genvar j = 0; j < F; j++)
    begin : g_step
        logic [VW-2:0]      src_rem;
        logic [VW-2:0]      src_den;
        logic [F-1:0]       src_q;
        cpt_pkg::div_mode_t src_mode;
        logic [VW-1:0]      shifted;
        logic               ge;

        if (j == 0)
        begin : g_first
            assign src_rem = rem_in;
            assign src_den = den_in;
            assign src_q = '0;
            assign src_mode = mode_in;
        end
        else
        begin : g_next
            assign src_rem = rem_reg[j-1];
            assign src_den = den_reg[j-1];
            assign src_q = q_reg[j-1];
            assign src_mode = mode_reg[j-1];
        end

        assign shifted = {src_rem, 1'b0};
        assign ge = shifted >= {1'b0, src_den};

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                rem_reg[j] <= ge ? (VW-1)'(shifted - {1'b0, src_den}) : (VW-1)'(shifted);
                den_reg[j] <= src_den;
                q_reg[j] <= {src_q[F-2:0], ge};
                mode_reg[j] <= src_mode;
            end
        end
    end

    always_comb
    begin
        priority if (mode_reg[F-1].zero)
            q_out = '0;
        else if (mode_reg[F-1].one)
            q_out = (F+1)'(1) << F;
        else
            q_out = {1'b0, q_reg[F-1]};
    end

endmodule

`default_nettype wire

FILE: hdl/cpt_emit.sv
`default_nettype none

module cpt_emit #(
    parameter int CW = 24,
    parameter int F = 12,
    localparam int DW = CW + 1,
    localparam int MW = DW + F + 2,
    localparam int AW = MW + 1,
    localparam int SW = AW + 1
) (
    input  logic                   clk,
    input  logic [1:0]             en,
    input  logic signed [CW-1:0]   base [3],
    input  logic signed [DW-1:0]   e1 [3],
    input  logic signed [DW-1:0]   e2 [3],
    input  logic [F:0]             t1,
    input  logic [F:0]             t2,
    input  cpt_pkg::region_t       region_in,
    output logic signed [CW-1:0]   near [3],
    output cpt_pkg::region_t       region_out
);

    localparam logic signed [SW-1:0] HI_LIM = SW'((longint'(1) <<< (CW - 1)) - 1);
    localparam logic signed [SW-1:0] LO_LIM = SW'(-(longint'(1) <<< (CW - 1)));

    logic signed [MW-1:0] m1_reg [3];
    logic signed [MW-1:0] m2_reg [3];
    logic signed [CW-1:0] base_reg [3];
    cpt_pkg::region_t     rgn_reg;
    logic signed [SW-1:0] sum [3];
    logic signed [CW-1:0] sat [3];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int k = 0; k < 3; k++)
            begin
                m1_reg[k] <= e1[k] * $signed({1'b0, t1});
                m2_reg[k] <= e2[k] * $signed({1'b0, t2});
                base_reg[k] <= base[k];
            end
            rgn_reg <= region_in;
        end
    end

    // round half up, then saturate to the coordinate range
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sum[k] = SW'((AW'(m1_reg[k]) + AW'(m2_reg[k]) + (AW'(1) <<< (F - 1))) >>> F)
                     + SW'(base_reg[k]);
            priority if (sum[k] > HI_LIM)
                sat[k] = CW'(HI_LIM);
            else if (sum[k] < LO_LIM)
                sat[k] = CW'(LO_LIM);
            else
                sat[k] = CW'(sum[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int k = 0; k < 3; k++)
            begin
                near[k] <= sat[k];
            end
            region_out <= rgn_reg;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/closest_point_on_triangle_core.sv
// throughput: one transaction per cycle while out_stall is low; stages advance independently and fill bubbles
// the quotient pipeline (one bit per stage, FRAC_BITS stages) sets the depth
// reset (rst_n, async, active low) clears the stage valid bits only
`default_nettype none

module closest_point_on_triangle_core #(
    parameter int COORD_BITS = 24,
    parameter int FRAC_BITS = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_y,
    input  logic signed [COORD_BITS-1:0] point_z,
    input  logic signed [COORD_BITS-1:0] tri_a_x,
    input  logic signed [COORD_BITS-1:0] tri_a_y,
    input  logic signed [COORD_BITS-1:0] tri_a_z,
    input  logic signed [COORD_BITS-1:0] tri_b_x,
    input  logic signed [COORD_BITS-1:0] tri_b_y,
    input  logic signed [COORD_BITS-1:0] tri_b_z,
    input  logic signed [COORD_BITS-1:0] tri_c_x,
    input  logic signed [COORD_BITS-1:0] tri_c_y,
    input  logic signed [COORD_BITS-1:0] tri_c_z,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [COORD_BITS-1:0] near_x,
    output logic signed [COORD_BITS-1:0] near_y,
    output logic signed [COORD_BITS-1:0] near_z,
    output logic [2:0]                   region
);

    localparam int CW = COORD_BITS;
    localparam int F = FRAC_BITS;
    localparam int DW = CW + 1;
    localparam int DTW = 2 * DW + 2 - F;
    localparam int VW = 2 * DTW + 3;
    localparam int NS = F + 8;
    localparam int SEL = 5;

    logic [NS-1:0] v_reg;
    logic [NS:0]   ld;

    logic signed [CW-1:0] p_w [3];
    logic signed [CW-1:0] a_w [3];
    logic signed [CW-1:0] b_w [3];
    logic signed [CW-1:0] c_w [3];

    logic signed [DTW-1:0] d3_w [6];
    logic signed [CW-1:0]  a3_w [3];
    logic signed [CW-1:0]  b3_w [3];
    logic signed [CW-1:0]  c3_w [3];
    logic signed [DW-1:0]  ab3_w [3];
    logic signed [DW-1:0]  ac3_w [3];
    logic signed [DW-1:0]  bc3_w [3];

    logic signed [CW-1:0] a4_reg [3];
    logic signed [CW-1:0] b4_reg [3];
    logic signed [CW-1:0] c4_reg [3];
    logic signed [DW-1:0] ab4_reg [3];
    logic signed [DW-1:0] ac4_reg [3];
    logic signed [DW-1:0] bc4_reg [3];
    logic signed [CW-1:0] a5_reg [3];
    logic signed [CW-1:0] b5_reg [3];
    logic signed [CW-1:0] c5_reg [3];
    logic signed [DW-1:0] ab5_reg [3];
    logic signed [DW-1:0] ac5_reg [3];
    logic signed [DW-1:0] bc5_reg [3];

    logic signed [DTW-1:0] d5_w [6];
    logic signed [VW-1:0]  va_w;
    logic signed [VW-1:0]  vb_w;
    logic signed [VW-1:0]  vc_w;
    logic signed [VW-1:0]  den_w;

    logic signed [DTW:0]   d43;
    logic signed [DTW:0]   d56;
    logic signed [DTW:0]   d13;
    logic signed [DTW:0]   d26;
    logic signed [DTW+1:0] dbc;

    cpt_pkg::region_t     sel_region;
    logic signed [CW-1:0] sel_base [3];
    logic signed [DW-1:0] sel_e1 [3];
    logic signed [DW-1:0] sel_e2 [3];
    logic signed [VW-1:0] n0;
    logic signed [VW-1:0] dn0;
    logic signed [VW-1:0] n1;
    logic signed [VW-1:0] dn1;
    logic                 use0;
    logic                 use1;
    cpt_pkg::div_mode_t   mode0;
    cpt_pkg::div_mode_t   mode1;

    cpt_pkg::region_t     rgn_reg;
    logic signed [CW-1:0] base_reg [3];
    logic signed [DW-1:0] e1_reg [3];
    logic signed [DW-1:0] e2_reg [3];
    logic [VW-2:0]        rem0_reg;
    logic [VW-2:0]        den0_reg;
    logic [VW-2:0]        rem1_reg;
    logic [VW-2:0]        den1_reg;
    cpt_pkg::div_mode_t   mode0_reg;
    cpt_pkg::div_mode_t   mode1_reg;

    cpt_pkg::region_t     rgn_d_reg [F];
    logic signed [CW-1:0] base_d_reg [F][3];
    logic signed [DW-1:0] e1_d_reg [F][3];
    logic signed [DW-1:0] e2_d_reg [F][3];

    logic [F:0]           t0_w;
    logic [F:0]           t1_w;
    logic signed [CW-1:0] near_w [3];
    cpt_pkg::region_t     region_w;

    // a stage loads when it is empty or the stage after it loads
    always_comb
    begin
        ld[NS] = !out_stall;
        for (int k = NS - 1; k >= 0; k--)
        begin
            ld[k] = !v_reg[k] || ld[k+1];
        end
    end

    assign in_stall = !ld[0];
    assign out_valid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (ld[0])
                v_reg[0] <= in_valid;
            for (int k = 1; k < NS; k++)
            begin
                if (ld[k])
                    v_reg[k] <= v_reg[k-1];
            end
        end
    end

    assign p_w = '{point_x, point_y, point_z};
    assign a_w = '{tri_a_x, tri_a_y, tri_a_z};
    assign b_w = '{tri_b_x, tri_b_y, tri_b_z};
    assign c_w = '{tri_c_x, tri_c_y, tri_c_z};

    cpt_dots #(
        .CW (CW),
        .F  (F)
    ) u_dots (
        .clk    (clk),
        .en     (ld[2:0]),
        .p      (p_w),
        .a      (a_w),
        .b      (b_w),
        .c      (c_w),
        .d      (d3_w),
        .a_out  (a3_w),
        .b_out  (b3_w),
        .c_out  (c3_w),
        .ab_out (ab3_w),
        .ac_out (ac3_w),
        .bc_out (bc3_w)
    );

    cpt_cross #(
        .DTW (DTW)
    ) u_cross (
        .clk   (clk),
        .en    (ld[4:3]),
        .d_in  (d3_w),
        .d_out (d5_w),
        .va    (va_w),
        .vb    (vb_w),
        .vc    (vc_w),
        .den   (den_w)
    );

    // corners and edges ride alongside the cross products
    always_ff @(posedge clk)
    begin
        if (ld[3])
        begin
            a4_reg <= a3_w;
            b4_reg <= b3_w;
            c4_reg <= c3_w;
            ab4_reg <= ab3_w;
            ac4_reg <= ac3_w;
            bc4_reg <= bc3_w;
        end
        if (ld[4])
        begin
            a5_reg <= a4_reg;
            b5_reg <= b4_reg;
            c5_reg <= c4_reg;
            ab5_reg <= ab4_reg;
            ac5_reg <= ac4_reg;
            bc5_reg <= bc4_reg;
        end
    end

    assign d13 = (DTW+1)'(d5_w[0]) - (DTW+1)'(d5_w[2]);
    assign d26 = (DTW+1)'(d5_w[1]) - (DTW+1)'(d5_w[5]);
    assign d43 = (DTW+1)'(d5_w[3]) - (DTW+1)'(d5_w[2]);
    assign d56 = (DTW+1)'(d5_w[4]) - (DTW+1)'(d5_w[5]);
    assign dbc = (DTW+2)'(d43) + (DTW+2)'(d56);

    // region tests in the standard order
    always_comb
    begin
        sel_region = cpt_pkg::RGN_A;
        sel_base = a5_reg;
        for (int k = 0; k < 3; k++)
        begin
            sel_e1[k] = '0;
            sel_e2[k] = '0;
        end
        n0 = '0;
        dn0 = '0;
        n1 = '0;
        dn1 = '0;
        use0 = 1'b0;
        use1 = 1'b0;
        priority if (d5_w[0] <= 0 && d5_w[1] <= 0)
        begin
            sel_region = cpt_pkg::RGN_A;
        end
        else if (d5_w[2] >= 0 && d5_w[3] <= d5_w[2])
        begin
            sel_region = cpt_pkg::RGN_B;
            sel_base = b5_reg;
        end
        else if (vc_w <= 0 && d5_w[0] >= 0 && d5_w[2] <= 0)
        begin
            sel_region = cpt_pkg::RGN_AB;
            sel_e1 = ab5_reg;
            n0 = VW'(d5_w[0]);
            dn0 = VW'(d13);
            use0 = 1'b1;
        end
        else if (d5_w[5] >= 0 && d5_w[4] <= d5_w[5])
        begin
            sel_region = cpt_pkg::RGN_C;
            sel_base = c5_reg;
        end
        else if (vb_w <= 0 && d5_w[1] >= 0 && d5_w[5] <= 0)
        begin
            sel_region = cpt_pkg::RGN_AC;
            sel_e1 = ac5_reg;
            n0 = VW'(d5_w[1]);
            dn0 = VW'(d26);
            use0 = 1'b1;
        end
        else if (va_w <= 0 && d43 >= 0 && d56 >= 0)
        begin
            sel_region = cpt_pkg::RGN_BC;
            sel_base = b5_reg;
            sel_e1 = bc5_reg;
            n0 = VW'(d43);
            dn0 = VW'(dbc);
            use0 = 1'b1;
        end
        else if (den_w <= 0)
        begin
            sel_region = cpt_pkg::RGN_DEGEN;
        end
        else
        begin
            sel_region = cpt_pkg::RGN_INT;
            sel_e1 = ab5_reg;
            sel_e2 = ac5_reg;
            n0 = vb_w;
            dn0 = den_w;
            n1 = vc_w;
            dn1 = den_w;
            use0 = 1'b1;
            use1 = 1'b1;
        end

        // clamp cases settle here, the divider only runs the strict fraction
        mode0.zero = !use0 || dn0 <= 0 || n0 <= 0;
        mode0.one = !mode0.zero && n0 >= dn0;
        mode1.zero = !use1 || dn1 <= 0 || n1 <= 0;
        mode1.one = !mode1.zero && n1 >= dn1;
    end

    always_ff @(posedge clk)
    begin
        if (ld[SEL])
        begin
            rgn_reg <= sel_region;
            base_reg <= sel_base;
            e1_reg <= sel_e1;
            e2_reg <= sel_e2;
            rem0_reg <= n0[VW-2:0];
            den0_reg <= dn0[VW-2:0];
            rem1_reg <= n1[VW-2:0];
            den1_reg <= dn1[VW-2:0];
            mode0_reg <= mode0;
            mode1_reg <= mode1;
        end
    end

    cpt_div #(
        .VW (VW),
        .F  (F)
    ) u_div0 (
        .clk     (clk),
        .en      (ld[SEL+F:SEL+1]),
        .rem_in  (rem0_reg),
        .den_in  (den0_reg),
        .mode_in (mode0_reg),
        .q_out   (t0_w)
    );

    cpt_div #(
        .VW (VW),
        .F  (F)
    ) u_div1 (
        .clk     (clk),
        .en      (ld[SEL+F:SEL+1]),
        .rem_in  (rem1_reg),
        .den_in  (den1_reg),
        .mode_in (mode1_reg),
        .q_out   (t1_w)
    );

    for (genvar j = 0; j < F; j++)
    begin : g_delay
        if (j == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (ld[SEL+1])
                begin
                    rgn_d_reg[0] <= rgn_reg;
                    base_d_reg[0] <= base_reg;
                    e1_d_reg[0] <= e1_reg;
                    e2_d_reg[0] <= e2_reg;
                end
            end
        end
        else
        begin : g_next
            always_ff @(posedge clk)
            begin
                if (ld[SEL+1+j])
                begin
                    rgn_d_reg[j] <= rgn_d_reg[j-1];
                    base_d_reg[j] <= base_d_reg[j-1];
                    e1_d_reg[j] <= e1_d_reg[j-1];
                    e2_d_reg[j] <= e2_d_reg[j-1];
                end
            end
        end
    end

    cpt_emit #(
        .CW (CW),
        .F  (F)
    ) u_emit (
        .clk        (clk),
        .en         (ld[NS-1:NS-2]),
        .base       (base_d_reg[F-1]),
        .e1         (e1_d_reg[F-1]),
        .e2         (e2_d_reg[F-1]),
        .t1         (t0_w),
        .t2         (t1_w),
        .region_in  (rgn_d_reg[F-1]),
        .near       (near_w),
        .region_out (region_w)
    );

    assign near_x = near_w[0];
    assign near_y = near_w[1];
    assign near_z = near_w[2];
    assign region = region_w;

`ifndef NO_ASSERTIONS
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (&v_reg && out_stall) |-> in_stall)
        else $error("pipeline full and stalled but input not stalled");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[0] |-> !in_stall)
        else $error("first stage empty but input stalled");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> v_reg[0])
        else $error("accepted transaction did not enter the first stage");

    a_div_mode: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[SEL] |-> !(mode0_reg.zero && mode0_reg.one))
        else $error("divider lane forced to both zero and one");
`endif

endmodule

`default_nettype wire
